FILE: hdl/sad_pkg.sv
// ----------------------------------------------------------------------------
// sad_pkg
// Shared types and constants of the shift array deque: command codes,
// status codes, payload structs and the control word that goes to every cell.
// ----------------------------------------------------------------------------
package sad_pkg;

  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int INDEX_W     = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int CAP_W       = 5;
  localparam int DEPTH_DFLT  = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REM_HEAD = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REM_TAIL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REPLACE  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INS_HEAD,
    OP_INS_TAIL,
    OP_REM_HEAD,
    OP_REM_TAIL,
    OP_REPLACE
  } sad_op_e;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [DATA_W-1:0]  data;
    logic [INDEX_W-1:0]        index;
  } sad_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  removed_word;
    logic [COUNT_W-1:0]        count;
  } sad_result_t;

  // what every cell sees in a cycle
  typedef struct packed {
    sad_op_e                   op;
    logic [DATA_W-1:0]         word;
    logic [INDEX_W-1:0]        index;
  } sad_ctrl_t;

endpackage

FILE: hdl/sad_cell.sv
// ----------------------------------------------------------------------------
// sad_cell
// One slot of the deque. Loads the new word, its left or right neighbor,
// zero, or holds, depending on the broadcast operation and its own position.
// ----------------------------------------------------------------------------
module sad_cell import sad_pkg::*; #(
  parameter int DEPTH = DEPTH_DFLT,
  parameter int POS   = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sad_ctrl_t                        ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]       count_i,
  input  logic [DATA_W-1:0]                left_i,
  input  logic [DATA_W-1:0]                right_i,
  output logic [DATA_W-1:0]                slot_o,
  output logic [DATA_W-1:0]                tap_o
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(POS);
  localparam logic [CNT_W-1:0] NXT_POS = CNT_W'(POS + 1);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  logic [DATA_W-1:0] slot_q, slot_d;
  logic              is_last;

  // this cell holds the last stored word
  assign is_last = (count_i == NXT_POS);

  always_comb begin
    slot_d = slot_q;
    unique case (ctrl_i.op)
      OP_INS_HEAD: begin
        if (POS == 0) begin
          slot_d = ctrl_i.word;
        end else if (MY_POS <= count_i) begin
          slot_d = left_i;
        end
      end
      OP_INS_TAIL: begin
        if (count_i == MY_POS) begin
          slot_d = ctrl_i.word;
        end
      end
      OP_REM_HEAD: begin
        // shift down; everything from the new count up is cleared
        if (NXT_POS < count_i) begin
          slot_d = right_i;
        end else begin
          slot_d = '0;
        end
      end
      OP_REM_TAIL: begin
        if (count_i == ONE || is_last) begin
          slot_d = '0;
        end
      end
      OP_REPLACE: begin
        if (ctrl_i.index == INDEX_W'(POS)) begin
          slot_d = ctrl_i.word;
        end
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
  assign tap_o  = is_last ? slot_q : '0;

endmodule

FILE: hdl/shift_array_deque.sv
// ----------------------------------------------------------------------------
// shift_array_deque
// Deque kept in a row of slot cells ordered from slot 0, with head and tail
// insert and remove, and replace at any slot below the capacity in use.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  command   start, cmd_i                 taken when start && !busy
//  result    done_o, result_o             valid for one cycle on done_o
//  config    cfg_we_i, cfg_wdata_i        written when cfg_we_i
//
//  one command per clock: all cells load in parallel at the accepting edge,
//  and the result appears on the following cycle with done_o high.
//  busy stays low, so a new command can follow every cycle.
//  reset clears all slots and the count and sets the capacity to 16.
//  results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module shift_array_deque import sad_pkg::*; #(
  parameter int DEPTH = DEPTH_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sad_cmd_t           cmd_i,
  output logic               done_o,
  output sad_result_t        result_o,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CMP_W-1:0] CMP_DEPTH = CMP_W'(DEPTH);
  localparam logic [CMP_W-1:0] CMP_ONE   = CMP_W'(1);

  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               done_q;
  sad_result_t        result_q, result_d;

  logic               accept;
  logic [CMP_W-1:0]   cap_ext, eff_cap, count_ext, index_ext, count_d_ext;
  logic               full, empty, bad_index;
  sad_op_e            op;
  logic [STATUS_W-1:0] status;
  sad_ctrl_t          ctrl;
  logic [DATA_W-1:0]  tail_word, removed;

  logic [DATA_W-1:0]  slot_w [DEPTH];
  logic [DATA_W-1:0]  tap_w  [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // capacity clamped to 1 .. DEPTH
  assign cap_ext   = CMP_W'(cap_q);
  assign count_ext = CMP_W'(count_q);
  assign index_ext = CMP_W'(cmd_i.index);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_ONE;
    end else if (cap_ext > CMP_DEPTH) begin
      eff_cap = CMP_DEPTH;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full      = (count_ext >= eff_cap);
  assign empty     = (count_q == '0);
  assign bad_index = (index_ext >= eff_cap);

  always_comb begin
    op     = OP_NOP;
    status = ST_OK;
    unique case (cmd_i.func)
      FUNC_INS_HEAD: begin
        if (full) status = ST_FULL;
        else      op     = OP_INS_HEAD;
      end
      FUNC_INS_TAIL: begin
        if (full) status = ST_FULL;
        else      op     = OP_INS_TAIL;
      end
      FUNC_REM_HEAD: begin
        if (empty) status = ST_EMPTY;
        else       op     = OP_REM_HEAD;
      end
      FUNC_REM_TAIL: begin
        if (empty) status = ST_EMPTY;
        else       op     = OP_REM_TAIL;
      end
      FUNC_REPLACE: begin
        if (bad_index) status = ST_BADIDX;
        else           op     = OP_REPLACE;
      end
      default: begin
        op     = OP_NOP;
        status = ST_OK;
      end
    endcase
  end

  assign ctrl.op    = accept ? op : OP_NOP;
  assign ctrl.word  = cmd_i.data;
  assign ctrl.index = cmd_i.index;

  always_comb begin
    count_d = count_q;
    unique case (ctrl.op)
      OP_INS_HEAD, OP_INS_TAIL: count_d = count_q + CNT_W'(1);
      OP_REM_HEAD, OP_REM_TAIL: count_d = count_q - CNT_W'(1);
      default:                  count_d = count_q;
    endcase
  end

  // only the last stored cell drives its tap
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | tap_w[i];
    end
  end

  always_comb begin
    unique case (op)
      OP_REM_HEAD: removed = slot_w[0];
      OP_REM_TAIL: removed = tail_word;
      default:     removed = '0;
    endcase
  end

  assign count_d_ext           = CMP_W'(count_d);
  assign result_d.status       = status;
  assign result_d.removed_word = removed;
  assign result_d.count        = count_d_ext[COUNT_W-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = slot_w[g-1];
    end
    if (g == DEPTH-1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = slot_w[g+1];
    end

    sad_cell #(
      .DEPTH (DEPTH),
      .POS   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .slot_o  (slot_w[g]),
      .tap_o   (tap_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: hdl/sad_checker.sv
// ----------------------------------------------------------------------------
// sad_checker
// Port-level checks of the shift array deque, bound to the top level.
// ----------------------------------------------------------------------------
module sad_checker import sad_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         busy,
  input  sad_cmd_t     cmd_i,
  input  logic         done_o,
  input  sad_result_t  result_o
);

  // one result beat for each accepted command, on the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("no result beat after accepted command");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result beat without a command");

  // a failed command removes nothing
  a_fail_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |-> (result_o.removed_word == '0))
    else $error("removed word on a failed command");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EMPTY) |-> (result_o.count == '0))
    else $error("empty status with nonzero count");

  a_cmd_fields_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> !$isunknown(cmd_i.func))
    else $error("unknown command code on accepted beat");

endmodule

bind shift_array_deque sad_checker u_sad_checker (.*);
